>>> design/thc_pkg.sv
// thermal hold controller package: widths, constants, config register indexes
// and the command and status structs between controller and datapath
// no dependencies
package thc_pkg;

   // field widths
   localparam int TEMP_W     = 12;
   localparam int TGT_TEMP_W = 7;
   localparam int TGT_TIME_W = 10;
   localparam int LEVEL_W    = 8;
   localparam int HOLD_W     = 16;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TEMP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TIME = 1'b1;

   // register reset values
   localparam logic [TGT_TEMP_W-1:0] TARGET_TEMP_RST = 7'd95;
   localparam logic [TGT_TIME_W-1:0] TARGET_TIME_RST = 10'd30;

   // control law: heater = 82 - (target - 55) * 2 = HEAT_BASE - 2 * target
   localparam int HEAT_OFFSET = 82;
   localparam int HEAT_PIVOT  = 55;
   localparam int HEAT_BASE   = HEAT_OFFSET + 2 * HEAT_PIVOT;
   localparam logic [LEVEL_W-1:0] HEATER_OFF = 8'd255;

   // window average band, in whole degrees either side of target
   localparam int WINDOW_MARGIN = 2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the accepted item
      logic tick;      // apply a timer tick
      logic mul_hi;    // form upper-bound product
      logic cmp_hi;    // check upper bound, form lower-bound product
      logic cmp_lo;    // check lower bound
      logic load;      // update state and load the result register
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_tick;       // latched item is a timer tick
      logic hold_full;     // hold count has reached its limit
      logic close_window;  // tick pending and window holds samples
      logic out_free;      // result register can take a new item
   } dp_status_type;

endpackage

>>> design/thermal_hold_controller_top.sv
// Thermal hold controller. A timer tick item gives no result. A temperature
// sample item gives one result; for the first sample after a tick, if the
// window holds samples and the hold is not complete, the window average is
// checked against the upper and then the lower band edge through one shared
// multiplier (bound times sample count, compared with the window sum). The
// next item is taken while the last result still waits in the output
// register; a sample stalls only at its final step until that register frees.
// Both config registers may be written only while the block is idle.
//
// top level: joins the sequencer and datapath
// depends on thc_pkg, thc_ctrl, thc_dp
module thermal_hold_controller_top #(
   parameter int MAX_WINDOW_SAMPLES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [thc_pkg::TEMP_W-1:0]     req_temp_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [thc_pkg::LEVEL_W-1:0]    rsp_heater_level,
   output logic                           rsp_fan_on,
   output logic                           rsp_led_on,
   output logic                           rsp_hold_done,
   input  logic                           csr_wr_en,
   input  logic [thc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [thc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import thc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   thc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   thc_dp #(
      .MAX_WINDOW_SAMPLES (MAX_WINDOW_SAMPLES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_temp_sample  (req_temp_sample),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_heater_level (rsp_heater_level),
      .rsp_fan_on       (rsp_fan_on),
      .rsp_led_on       (rsp_led_on),
      .rsp_hold_done    (rsp_hold_done)
   );

   // a completed hold leaves heater, fan and indicator off
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hold_done |->
         (rsp_heater_level == HEATER_OFF) && !rsp_fan_on && !rsp_led_on)
      else $error("hold done item carries drive");

   // fan and in-band indicator are exclusive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_fan_on && rsp_led_on))
      else $error("fan and indicator both on");

   // one item in flight: ready drops after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   // heater is driven only when neither fan nor indicator is on
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fan_on || rsp_led_on) |-> rsp_heater_level == HEATER_OFF)
      else $error("heater on outside low band");

endmodule

>>> design/thc_dp.sv
// thermal hold controller datapath: config registers, window and hold state,
// shared bound multiplier, control law and result register
// depends on thc_pkg
module thc_dp #(
   parameter int MAX_WINDOW_SAMPLES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  thc_pkg::dp_cmd_type            cmd,
   output thc_pkg::dp_status_type         status,
   input  logic                           req_operation,
   input  logic [thc_pkg::TEMP_W-1:0]     req_temp_sample,
   input  logic                           csr_wr_en,
   input  logic [thc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [thc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [thc_pkg::LEVEL_W-1:0]    rsp_heater_level,
   output logic                           rsp_fan_on,
   output logic                           rsp_led_on,
   output logic                           rsp_hold_done
);
   import thc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_WINDOW_SAMPLES + 1);
   localparam int SUM_W  = CNT_W + TEMP_W;
   localparam int FACT_W = TGT_TEMP_W + 1;
   localparam int PROD_W = FACT_W + CNT_W;
   localparam int CMP_W  = PROD_W + 4;

   logic                  operation_ff;
   logic [TEMP_W-1:0]     sample_ff;
   logic [TGT_TEMP_W-1:0] target_temp_ff;
   logic [TGT_TIME_W-1:0] target_time_ff;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;
   logic                  pending_ff, pending_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  win_reset_ff;
   logic                  rsp_valid_ff;
   logic [LEVEL_W-1:0]    heater_ff, heater_in;
   logic                  fan_ff, fan_in;
   logic                  led_ff, led_in;
   logic                  done_ff, done_in;

   logic                  hold_full;
   logic [FACT_W-1:0]     factor;
   logic [CMP_W-1:0]      bound;
   logic                  above_hi;
   logic                  below_lo;
   logic                  low_valid;
   logic [TEMP_W-1:0]     thr_lo;
   logic [TEMP_W-1:0]     thr_hi;
   logic [8:0]            twice_t;
   logic [LEVEL_W-1:0]    drive;

   // status towards the controller
   assign hold_full = hold_ff >= {{(HOLD_W - TGT_TIME_W - 1){1'b0}}, target_time_ff, 1'b0};
   assign status.is_tick      = operation_ff;
   assign status.hold_full    = hold_full;
   assign status.close_window = pending_ff && (count_ff != '0);
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   // shared multiplier: (target +/- margin) * window count
   assign factor  = cmd.mul_hi ? (FACT_W'(target_temp_ff) + FACT_W'(WINDOW_MARGIN))
                               : (FACT_W'(target_temp_ff) - FACT_W'(WINDOW_MARGIN));
   assign prod_in = PROD_W'(factor) * PROD_W'(count_ff);

   // bound is product scaled to sixteenths
   assign bound     = {prod_ff, 4'b0000};
   assign above_hi  = CMP_W'(sum_ff) >= bound;
   assign below_lo  = CMP_W'(sum_ff) <= bound;
   assign low_valid = target_temp_ff >= TGT_TEMP_W'(WINDOW_MARGIN);

   // control law
   assign thr_lo  = {1'b0, target_temp_ff, 4'b0000};
   assign thr_hi  = {FACT_W'(target_temp_ff) + FACT_W'(1), 4'b0000};
   assign twice_t = {1'b0, target_temp_ff, 1'b0};
   assign drive   = (twice_t >= 9'(HEAT_BASE)) ? '0 : LEVEL_W'(9'(HEAT_BASE) - twice_t);

   // next state for a tick or a sample
   always_comb begin
      sum_in     = sum_ff;
      count_in   = count_ff;
      hold_in    = hold_ff;
      pending_in = pending_ff;
      heater_in  = HEATER_OFF;
      fan_in     = 1'b0;
      led_in     = 1'b0;
      done_in    = 1'b0;
      if (cmd.tick) begin
         if (hold_ff != '1) begin
            hold_in = hold_ff + HOLD_W'(1);
         end
         pending_in = 1'b1;
      end else if (hold_full) begin
         // hold complete: no regulation, everything but the tick flag clears
         hold_in  = '0;
         sum_in   = '0;
         count_in = '0;
         done_in  = 1'b1;
      end else begin
         if (sample_ff < thr_lo) begin
            heater_in = drive;
         end else if (sample_ff > thr_hi) begin
            fan_in = 1'b1;
         end else begin
            led_in = 1'b1;
         end
         if (!pending_ff) begin
            if (count_ff < CNT_W'(MAX_WINDOW_SAMPLES)) begin
               sum_in   = sum_ff + SUM_W'(sample_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if ((count_ff != '0) && win_reset_ff) begin
               hold_in = '0;
            end
            sum_in     = '0;
            count_in   = '0;
            pending_in = 1'b0;
         end
      end
   end

   // config registers and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_temp_ff <= TARGET_TEMP_RST;
         target_time_ff <= TARGET_TIME_RST;
         sum_ff         <= '0;
         count_ff       <= '0;
         hold_ff        <= '0;
         pending_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TARGET_TEMP: target_temp_ff <= csr_wdata[TGT_TEMP_W-1:0];
               CSR_TARGET_TIME: target_time_ff <= csr_wdata[TGT_TIME_W-1:0];
               default: ;
            endcase
         end
         if (cmd.tick || cmd.load) begin
            sum_ff     <= sum_in;
            count_ff   <= count_in;
            hold_ff    <= hold_in;
            pending_ff <= pending_in;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item capture, bound checks and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         operation_ff <= req_operation;
         sample_ff    <= req_temp_sample;
      end
      if (cmd.mul_hi || cmd.cmp_hi) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_hi) begin
         win_reset_ff <= 1'b0;
      end else if (cmd.cmp_hi) begin
         win_reset_ff <= above_hi;
      end else if (cmd.cmp_lo) begin
         win_reset_ff <= win_reset_ff || (low_valid && below_lo);
      end
      if (cmd.load) begin
         heater_ff <= heater_in;
         fan_ff    <= fan_in;
         led_ff    <= led_in;
         done_ff   <= done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_heater_level = heater_ff;
   assign rsp_fan_on       = fan_ff;
   assign rsp_led_on       = led_ff;
   assign rsp_hold_done    = done_ff;

endmodule

>>> design/thc_ctrl.sv
// thermal hold controller sequencer: accepts items and steps the datapath
// through capture, tick update, window bound checks and result load
// depends on thc_pkg
module thc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  thc_pkg::dp_status_type status,
   output thc_pkg::dp_cmd_type    cmd
);
   import thc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL_HI,
      ST_CMP_HI,
      ST_CMP_LO,
      ST_LOAD
   } state_type;

   state_type state_ff, state_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.is_tick) begin
               cmd.tick = 1'b1;
               state_in = ST_IDLE;
            end else if (!status.hold_full && status.close_window) begin
               state_in = ST_MUL_HI;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_CMP_HI;
         end
         ST_CMP_HI: begin
            cmd.cmp_hi = 1'b1;
            state_in   = ST_CMP_LO;
         end
         ST_CMP_LO: begin
            cmd.cmp_lo = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

>>> tb/thermal_hold_controller_top_tb.sv
// testbench for thermal_hold_controller_top: directed and random sample and tick items,
// self-checking against an in-bench prediction of the heater, fan, indicator and hold logic
// depends on thc_pkg and the thermal_hold_controller_top rtl
module thermal_hold_controller_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import thc_pkg::*;

   // item operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam int WINDOW_SAMPLES = 1024;
   localparam int HOLD_MAX       = 2**HOLD_W - 1;
   localparam int DRAIN_CYCLES   = 12;
   localparam int STALL_LIMIT    = 2000;
   localparam int HOLD_OFF_LEN   = 300;

   typedef struct packed {
      logic [LEVEL_W-1:0] heater_level;
      logic               fan_on;
      logic               led_on;
      logic               hold_done;
   } drive_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = OP_SAMPLE;
   logic [TEMP_W-1:0]     req_temp_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]    rsp_heater_level;
   logic                  rsp_fan_on;
   logic                  rsp_led_on;
   logic                  rsp_hold_done;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TARGET_TEMP;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted controller state and settings
   logic [TGT_TEMP_W-1:0] tgt_temp = TARGET_TEMP_RST;
   logic [TGT_TIME_W-1:0] tgt_time = TARGET_TIME_RST;
   logic [21:0]           win_sum = '0;
   logic [10:0]           win_cnt = '0;
   logic [HOLD_W-1:0]     hold_cnt = '0;
   logic                  tick_pend = 1'b0;

   drive_out_type expected_drive[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off_req = 1'b0;
   bit hold_off_seen = 1'b0;
   int hold_off_left = 0;
   int errors = 0;
   int items_sent = 0;
   int results_checked = 0;
   int holds_done = 0;

   thermal_hold_controller_top #(
      .MAX_WINDOW_SAMPLES(WINDOW_SAMPLES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_temp_sample (req_temp_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_heater_level(rsp_heater_level),
      .rsp_fan_on      (rsp_fan_on),
      .rsp_led_on      (rsp_led_on),
      .rsp_hold_done   (rsp_hold_done),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted drive for one item, updates the predicted state; returns 1 if a result follows
   function automatic bit predict_drive(input logic op, input logic [TEMP_W-1:0] temp,
                                        output drive_out_type drv);
      int t;
      int s;
      int level;
      bit too_hot;
      bit too_cold;
      t = int'(tgt_temp);
      s = int'(temp);
      drv = '0;
      // tick: advance the hold count, saturating, and mark the window for closing
      if (op == OP_TICK) begin
         if (int'(hold_cnt) < HOLD_MAX) hold_cnt = hold_cnt + 1'b1;
         tick_pend = 1'b1;
         return 1'b0;
      end
      // hold period complete: flag it and clear everything but the pending tick
      if (int'(hold_cnt) >= 2 * int'(tgt_time)) begin
         hold_cnt = '0;
         win_sum = '0;
         win_cnt = '0;
         drv.heater_level = HEATER_OFF;
         drv.hold_done = 1'b1;
         return 1'b1;
      end
      // control law
      if (s < 16 * t) begin
         level = HEAT_OFFSET + 2 * HEAT_PIVOT - 2 * t;
         if (level < 0) level = 0;
         if (level > 255) level = 255;
         drv.heater_level = level[LEVEL_W-1:0];
      end else if (s > 16 * (t + 1)) begin
         drv.heater_level = HEATER_OFF;
         drv.fan_on = 1'b1;
      end else begin
         drv.heater_level = HEATER_OFF;
         drv.led_on = 1'b1;
      end
      // window accumulation, or window close on the first sample after a tick
      if (!tick_pend) begin
         if (int'(win_cnt) < WINDOW_SAMPLES) begin
            win_sum = win_sum + temp;
            win_cnt = win_cnt + 1'b1;
         end
      end else begin
         if (win_cnt != 0) begin
            too_hot = int'(win_sum) >= (t + WINDOW_MARGIN) * 16 * int'(win_cnt);
            too_cold = (t >= WINDOW_MARGIN) &&
                       (int'(win_sum) <= (t - WINDOW_MARGIN) * 16 * int'(win_cnt));
            if (too_hot || too_cold) hold_cnt = '0;
         end
         win_sum = '0;
         win_cnt = '0;
         tick_pend = 1'b0;
      end
      return 1'b1;
   endfunction

   // temperature near the current target most of the time, otherwise anywhere
   function automatic logic [TEMP_W-1:0] pick_temp();
      int v;
      case ($urandom_range(9))
         0: v = int'($urandom_range(4095));
         1: v = $urandom_range(1) ? 4095 : 0;
         default: v = int'(tgt_temp) * 16 + int'($urandom_range(64)) - 28;
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[TEMP_W-1:0];
   endfunction

   // offer one item after a random gap and record its prediction on acceptance
   task automatic send_item(input logic op, input logic [TEMP_W-1:0] temp);
      int gap;
      drive_out_type drv;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_temp_sample = temp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_drive(op, temp, drv)) expected_drive.push_back(drv);
      items_sent++;
      @(negedge clock);
   endtask

   // stop offering, let every expected result drain, then allow for a trailing tick
   task automatic wait_idle();
      req_valid = 1'b0;
      while (expected_drive.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_TARGET_TEMP: tgt_temp = value[TGT_TEMP_W-1:0];
         CSR_TARGET_TIME: tgt_time = value[TGT_TIME_W-1:0];
         default: ;
      endcase
   endtask

   // new settings once idle; spare upper data bits on the temperature write are random
   task automatic configure(input int t, input int hold_time);
      wait_idle();
      write_reg(CSR_TARGET_TEMP, (int'($urandom_range(7)) << TGT_TEMP_W) | t);
      write_reg(CSR_TARGET_TIME, hold_time);
   endtask

   // thresholds around the reset target of 95 degrees
   task automatic test_control_law();
      send_item(OP_SAMPLE, 12'd1519);
      send_item(OP_SAMPLE, 12'd1520);
      send_item(OP_SAMPLE, 12'd1536);
      send_item(OP_SAMPLE, 12'd1537);
      send_item(OP_SAMPLE, 12'd4095);
   endtask

   // lowest and highest target, heater drive at its zero clamp
   task automatic test_target_extremes();
      configure(0, 30);
      send_item(OP_SAMPLE, 12'd0);
      send_item(OP_SAMPLE, 12'd17);
      configure(127, 30);
      send_item(OP_SAMPLE, 12'd2031);
      send_item(OP_SAMPLE, 12'd4095);
   endtask

   // window in band, window too hot, repeated ticks and an empty window
   task automatic test_window_close();
      configure(50, 30);
      send_item(OP_TICK, 12'($urandom));
      send_item(OP_SAMPLE, 12'd808);
      send_item(OP_SAMPLE, 12'd808);
      send_item(OP_TICK, 12'($urandom));
      send_item(OP_SAMPLE, 12'd900);
      send_item(OP_SAMPLE, 12'd840);
      send_item(OP_TICK, 12'($urandom));
      send_item(OP_TICK, 12'($urandom));
      send_item(OP_SAMPLE, 12'd808);
      send_item(OP_TICK, 12'($urandom));
      send_item(OP_SAMPLE, 12'd808);
   endtask

   // hold completion after two ticks, then a zero hold time
   task automatic test_hold_complete();
      configure(50, 1);
      send_item(OP_TICK, 12'($urandom));
      send_item(OP_TICK, 12'($urandom));
      send_item(OP_SAMPLE, 12'd808);
      configure(50, 0);
      send_item(OP_SAMPLE, 12'd808);
   endtask

   // lower band edge disabled below a target of two, active at and above it
   task automatic test_low_target();
      configure(1, 30);
      send_item(OP_SAMPLE, 12'd0);
      send_item(OP_TICK, 12'($urandom));
      send_item(OP_SAMPLE, 12'd0);
      configure(10, 30);
      send_item(OP_SAMPLE, 12'd0);
      send_item(OP_TICK, 12'($urandom));
      send_item(OP_SAMPLE, 12'd0);
   endtask

   // hot window past its sample capacity, then closed by a tick
   task automatic test_full_window();
      configure(127, 999);
      repeat (WINDOW_SAMPLES + 6) send_item(OP_SAMPLE, 12'($urandom_range(3900, 4095)));
      send_item(OP_TICK, 12'($urandom));
      send_item(OP_SAMPLE, 12'd2040);
   endtask

   // receiver holds off for a long stretch while samples keep coming
   task automatic test_backpressure();
      configure(60, 4);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_req = ~hold_off_req;
      repeat (40) begin
         send_item($urandom_range(3) == 0 ? OP_TICK : OP_SAMPLE, pick_temp());
      end
   endtask

   // windows of random length and content around the target, with noise and empty windows
   task automatic test_random_windows(input int n_items, input int send_pct, input int recv_pct,
                                      input int t, input int hold_time);
      int sent;
      int n_temps;
      int n_ticks;
      configure(t, hold_time);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      sent = 0;
      while (sent < n_items) begin
         n_temps = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
         repeat (n_temps) send_item(OP_SAMPLE, pick_temp());
         n_ticks = ($urandom_range(4) == 0) ? $urandom_range(2, 3) : 1;
         repeat (n_ticks) send_item(OP_TICK, 12'($urandom));
         sent += n_temps + n_ticks;
      end
   endtask

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_off_req != hold_off_seen) begin
         hold_off_seen = hold_off_req;
         hold_off_left = HOLD_OFF_LEN;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_drive
      drive_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drive.size() == 0) begin
            $error("result with nothing expected: heater_level %0d", rsp_heater_level);
            errors++;
         end else begin
            want = expected_drive.pop_front();
            if (rsp_heater_level !== want.heater_level) begin
               $error("heater_level expected %0d got %0d", want.heater_level, rsp_heater_level);
               errors++;
            end
            if (rsp_fan_on !== want.fan_on) begin
               $error("fan_on expected %0d got %0d", want.fan_on, rsp_fan_on);
               errors++;
            end
            if (rsp_led_on !== want.led_on) begin
               $error("led_on expected %0d got %0d", want.led_on, rsp_led_on);
               errors++;
            end
            if (rsp_hold_done !== want.hold_done) begin
               $error("hold_done expected %0d got %0d", want.hold_done, rsp_hold_done);
               errors++;
            end
            if (want.hold_done) holds_done++;
            results_checked++;
         end
      end
   end

   // watchdog: too long with no item moving on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("[thermal_hold_controller_top] ERROR");
      $finish;
   end

   // test sequence
   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_control_law();
      test_target_extremes();
      test_window_close();
      test_hold_complete();
      test_low_target();
      test_full_window();
      test_random_windows(180, 0, 0, 95, 3);
      test_random_windows(180, 72, 0, 0, 1);
      test_random_windows(180, 0, 72, 127, 999);
      test_random_windows(180, 20, 20, $urandom_range(2, 126), $urandom_range(1, 4));
      test_backpressure();
      recv_stall_pct = 0;
      wait_idle();
      $display("covered control law edges, target and hold time extremes, window close, ");
      $display("full window, back-pressure: %0d items, %0d results, %0d holds",
               items_sent, results_checked, holds_done);
      if (errors == 0) begin
         $display("[thermal_hold_controller_top] OK");
      end else begin
         $display("[thermal_hold_controller_top] ERROR");
      end
      $finish;
   end

endmodule
